>>> hw/rtl/slpl_pkg.sv
package slpl_pkg;

    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LINE_W = 24;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_GOTO   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_FINISH = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_ACK       = 3'd0,
        ST_SELECTED  = 3'd1,
        ST_DEFERRED  = 3'd2,
        ST_UNCHANGED = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [LINE_W-1:0]   line_number;
        logic                records_present;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    selected_index;
        logic [LINE_W-1:0]   selected_line;
    } t_rsp;

    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    waddr;
        logic [LINE_W-1:0]   wdata;
        logic                re;
        logic [IDX_W-1:0]    raddr;
    } t_mem_req;

endpackage

>>> hw/rtl/sorted_line_predecessor_lookup.sv
// Append, clear, finish, deferred, empty: result in the cycle after the request.
// A step forward reads the next entry; a step back reads the current entry and,
// if above the line, the one before; a binary search does one table read per probe.
// Throughput: one request per cycle; a step or search holds busy until its result.
// Reset is synchronous and clears control state; table contents stay undefined.
// The result strobe lasts one cycle; the receiver cannot stall.
module sorted_line_predecessor_lookup (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  slpl_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_valid,
    output slpl_pkg::t_rsp  o_rsp
);
    import slpl_pkg::*;

    t_mem_req           mem_req;
    logic [LINE_W-1:0]  mem_rdata;

    slpl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .i_rdata (mem_rdata),
        .o_mem   (mem_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    slpl_mem u_mem (
        .i_clk   (i_clk),
        .i_mem   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

>>> hw/rtl/slpl_mem.sv
module slpl_mem (
    input  logic                    i_clk,
    input  slpl_pkg::t_mem_req      i_mem,
    output logic [slpl_pkg::LINE_W-1:0] o_rdata
);
    import slpl_pkg::*;

    logic [LINE_W-1:0] r_mem [DEPTH];
    logic [LINE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        if (i_mem.re) begin
            r_rdata <= r_mem[i_mem.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/slpl_ctrl.sv
module slpl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  slpl_pkg::t_req              i_req,
    output logic                        o_busy,
    input  logic [slpl_pkg::LINE_W-1:0] i_rdata,
    output slpl_pkg::t_mem_req          o_mem,
    output logic                        o_valid,
    output slpl_pkg::t_rsp              o_rsp
);
    import slpl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FWD    = 5'b00010,
        S_BACK   = 5'b00100,
        S_SEARCH = 5'b01000,
        S_FETCH  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LINE_W-1:0]  r_cur_line, n_cur_line;
    logic [LINE_W-1:0]  r_pending, n_pending;
    logic               r_ready, n_ready;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [IDX_W-1:0]   r_mid, n_mid;
    logic               r_valid, n_valid;
    t_rsp               r_rsp, n_rsp;

    // goto decode
    logic               go;
    logic               go_ready;
    logic [LINE_W-1:0]  go_line;
    logic [LINE_W-1:0]  diff;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   init_sum;

    // search step (hi is one past the upper bound)
    logic               s_eq;
    logic               s_gt;
    logic [CNT_W-1:0]   s_lo;
    logic [CNT_W-1:0]   s_hi;
    logic [CNT_W:0]     s_sum;
    logic [IDX_W-1:0]   s_idx;

    assign go = i_start && ((i_req.action == ACT_GOTO) ||
                            ((i_req.action == ACT_FINISH) && i_req.records_present &&
                             (r_pending != '0)));
    assign go_ready = r_ready || (i_req.action == ACT_FINISH);
    assign go_line  = (i_req.action == ACT_GOTO) ? i_req.line_number : r_pending;
    assign diff     = go_line - r_cur_line;
    assign idx_inc  = {1'b0, r_idx} + CNT_W'(1);
    assign init_sum = r_count - CNT_W'(1);

    assign s_eq  = (i_rdata == r_cur_line);
    assign s_gt  = (r_cur_line > i_rdata);
    assign s_lo  = s_gt ? ({1'b0, r_mid} + CNT_W'(1)) : r_lo;
    assign s_hi  = s_gt ? r_hi : {1'b0, r_mid};
    assign s_sum = {1'b0, s_lo} + {1'b0, s_hi} - (CNT_W+1)'(1);
    assign s_idx = s_gt ? r_mid : r_idx;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_cur_line = r_cur_line;
        n_pending  = r_pending;
        n_ready    = r_ready;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;
        o_mem      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (go) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: ST_ACK, selected_index: '0, selected_line: '0};
                    if (i_req.action == ACT_FINISH) begin
                        n_ready = 1'b1;
                    end
                    if (!go_ready) begin
                        n_pending    = go_line;
                        n_rsp.status = ST_DEFERRED;
                    end else if (r_count == '0) begin
                        n_rsp.status = ST_EMPTY;
                    end else begin
                        n_cur_line = go_line;
                        if (diff == LINE_W'(1)) begin
                            if (idx_inc < r_count) begin
                                n_valid     = 1'b0;
                                o_mem.re    = 1'b1;
                                o_mem.raddr = idx_inc[IDX_W-1:0];
                                n_state     = S_FWD;
                            end else begin
                                n_rsp.status = ST_UNCHANGED;
                            end
                        end else if (diff == '1) begin
                            if ((r_idx != '0) && ({1'b0, r_idx} < r_count)) begin
                                n_valid     = 1'b0;
                                o_mem.re    = 1'b1;
                                o_mem.raddr = r_idx;
                                n_state     = S_BACK;
                            end else begin
                                n_rsp.status = ST_UNCHANGED;
                            end
                        end else begin
                            n_valid     = 1'b0;
                            n_idx       = '0;
                            n_lo        = '0;
                            n_hi        = r_count;
                            n_mid       = init_sum[IDX_W:1];
                            o_mem.re    = 1'b1;
                            o_mem.raddr = init_sum[IDX_W:1];
                            n_state     = S_SEARCH;
                        end
                    end
                end else if (i_start) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: ST_ACK, selected_index: '0, selected_line: '0};
                    unique case (i_req.action)
                        ACT_APPEND: begin
                            if (r_count < CNT_W'(DEPTH)) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_count[IDX_W-1:0];
                                o_mem.wdata = i_req.line_number;
                                n_count     = r_count + CNT_W'(1);
                            end else begin
                                n_rsp.status = ST_FULL;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count    = '0;
                            n_idx      = '0;
                            n_cur_line = '0;
                            n_pending  = '0;
                            n_ready    = 1'b0;
                        end
                        ACT_FINISH: begin
                            if (i_req.records_present) begin
                                n_ready = 1'b1;
                            end
                        end
                        ACT_GOTO: begin
                            n_rsp.status = ST_ACK;
                        end
                    endcase
                end
            end
            S_FWD: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (i_rdata == r_cur_line) begin
                    n_idx     = idx_inc[IDX_W-1:0];
                    n_pending = '0;
                    n_rsp     = '{status: ST_SELECTED, selected_index: idx_inc[IDX_W-1:0],
                                  selected_line: r_cur_line};
                end else begin
                    n_rsp = '{status: ST_UNCHANGED, selected_index: '0, selected_line: '0};
                end
            end
            S_BACK: begin
                if (i_rdata > r_cur_line) begin
                    n_idx       = r_idx - IDX_W'(1);
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_idx - IDX_W'(1);
                    n_state     = S_FETCH;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    n_rsp   = '{status: ST_UNCHANGED, selected_index: '0, selected_line: '0};
                end
            end
            S_SEARCH: begin
                if (s_eq) begin
                    n_idx     = r_mid;
                    n_pending = '0;
                    n_valid   = 1'b1;
                    n_state   = S_IDLE;
                    n_rsp     = '{status: ST_SELECTED, selected_index: r_mid,
                                  selected_line: i_rdata};
                end else begin
                    n_idx    = s_idx;
                    n_lo     = s_lo;
                    n_hi     = s_hi;
                    o_mem.re = 1'b1;
                    if (s_lo < s_hi) begin
                        n_mid       = s_sum[IDX_W:1];
                        o_mem.raddr = s_sum[IDX_W:1];
                    end else begin
                        o_mem.raddr = s_idx;
                        n_state     = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_pending = '0;
                n_valid   = 1'b1;
                n_state   = S_IDLE;
                n_rsp     = '{status: ST_SELECTED, selected_index: r_idx,
                              selected_line: i_rdata};
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_cur_line <= '0;
            r_pending  <= '0;
            r_ready    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_cur_line <= n_cur_line;
            r_pending  <= n_pending;
            r_ready    <= n_ready;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_rsp <= n_rsp;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

>>> hw/rtl/slpl_chk.sv
module slpl_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input slpl_pkg::t_req  i_req,
    input logic            busy,
    input logic            o_valid,
    input slpl_pkg::t_rsp  o_rsp
);
    import slpl_pkg::*;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted request neither answered nor in progress");

    a_busy_ends_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != ST_SELECTED)) |->
            ((o_rsp.selected_index == '0) && (o_rsp.selected_line == '0)))
        else $error("nonzero selection fields on non-selected result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status <= ST_FULL))
        else $error("status code out of range");

endmodule

bind sorted_line_predecessor_lookup slpl_chk u_chk (.*);

>>> tb/sv/tb_sorted_line_predecessor_lookup.sv
`timescale 1ns / 1ps

module tb_sorted_line_predecessor_lookup;
    import slpl_pkg::*;

    localparam int RAND_ITEMS   = 900;
    localparam int WDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    t_req   i_req = '0;
    logic   busy;
    logic   o_valid;
    t_rsp   o_rsp;

    t_req   pending_reqs[$];
    t_rsp   lookup_results_due[$];
    int     total_reqs = 0;
    int     n_issued = 0;
    int     n_errs = 0;
    int     stall_cycles = 0;

    // Predictor state
    logic [LINE_W-1:0] tag_lines [DEPTH];
    int                n_tags = 0;
    int                cur_idx = 0;
    logic [LINE_W-1:0] cur_line = '0;
    logic [LINE_W-1:0] held_line = '0;
    logic              loaded = 1'b0;

    // Stimulus-side view of the table contents
    logic [LINE_W-1:0] gen_lines[$];
    logic [LINE_W-1:0] last_goto = '0;

    sorted_line_predecessor_lookup u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_rsp seek_line(logic [LINE_W-1:0] ln);
        t_rsp              r;
        logic [LINE_W-1:0] diff;
        int                lo;
        int                hi;
        int                mid;
        r = '0;
        if (!loaded) begin
            held_line = ln;
            r.status = ST_DEFERRED;
            return r;
        end
        if (n_tags == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        diff = ln - cur_line;
        cur_line = ln;
        if (diff == 1) begin
            if (cur_idx + 1 < n_tags && tag_lines[cur_idx + 1] == ln) begin
                cur_idx++;
            end else begin
                r.status = ST_UNCHANGED;
                return r;
            end
        end else if (diff == LINE_MAX) begin
            if (cur_idx > 0 && cur_idx < n_tags && tag_lines[cur_idx] > ln) begin
                cur_idx--;
            end else begin
                r.status = ST_UNCHANGED;
                return r;
            end
        end else begin
            lo = 0;
            hi = n_tags - 1;
            cur_idx = 0;
            do begin
                mid = (lo + hi) / 2;
                if (tag_lines[mid] == ln) begin
                    cur_idx = mid;
                    break;
                end else if (ln > tag_lines[mid]) begin
                    cur_idx = mid;
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end while (lo <= hi);
        end
        held_line = '0;
        r.status = ST_SELECTED;
        r.selected_index = cur_idx[IDX_W-1:0];
        r.selected_line = tag_lines[cur_idx];
        return r;
    endfunction

    function automatic t_rsp predict_lookup(t_req rq);
        t_rsp r;
        r = '0;
        r.status = ST_ACK;
        case (rq.action)
            ACT_APPEND: begin
                if (n_tags < DEPTH) begin
                    tag_lines[n_tags] = rq.line_number;
                    n_tags++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            ACT_GOTO: begin
                r = seek_line(rq.line_number);
            end
            ACT_CLEAR: begin
                n_tags = 0;
                cur_idx = 0;
                cur_line = '0;
                held_line = '0;
                loaded = 1'b0;
            end
            ACT_FINISH: begin
                if (rq.records_present) begin
                    loaded = 1'b1;
                    if (held_line != 0) begin
                        r = seek_line(held_line);
                    end
                end
            end
            default: begin
                r.status = ST_ACK;
            end
        endcase
        return r;
    endfunction

    task automatic push_req(t_action act, logic [LINE_W-1:0] ln, logic rp);
        t_req rq;
        rq.action = act;
        rq.line_number = ln;
        rq.records_present = rp;
        pending_reqs.push_back(rq);
        if (act == ACT_CLEAR) begin
            gen_lines.delete();
            last_goto = '0;
        end else if (act == ACT_APPEND) begin
            gen_lines.push_back(ln);
        end else if (act == ACT_GOTO) begin
            last_goto = ln;
        end
    endtask

    task automatic push_noise();
        push_req(t_action'($urandom_range(0, 3)), LINE_W'($urandom), 1'($urandom));
    endtask

    task automatic gen_session(bit fill);
        int          n_app;
        int          n_goto;
        int          step_max;
        int unsigned ln;
        logic [LINE_W-1:0] pick;
        if ($urandom_range(0, 9) != 0) begin
            push_req(ACT_CLEAR, LINE_W'($urandom), 1'($urandom));
        end
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 3) == 0) begin
                push_req(ACT_GOTO, '0, 1'($urandom));
            end else begin
                push_req(ACT_GOTO, LINE_W'($urandom_range(0, 2000)), 1'($urandom));
            end
        end
        if (fill) begin
            n_app = DEPTH + 2;
            step_max = 8000;
        end else begin
            n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                : $urandom_range(0, 40);
            step_max = ($urandom_range(0, 3) == 0) ? 100000 : 3;
        end
        ln = $urandom_range(0, 50);
        for (int i = 0; i < n_app; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                push_req(ACT_APPEND, LINE_W'($urandom), 1'($urandom));
            end else begin
                ln += $urandom_range(0, step_max);
                if (ln > LINE_MAX) begin
                    ln = LINE_MAX;
                end
                push_req(ACT_APPEND, LINE_W'(ln), 1'($urandom));
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            push_req(ACT_FINISH, LINE_W'($urandom), 1'b0);
            push_req(ACT_GOTO, LINE_W'($urandom_range(0, 5000)), 1'($urandom));
        end
        push_req(ACT_FINISH, LINE_W'($urandom), ($urandom_range(0, 9) != 0));
        n_goto = $urandom_range(5, 40);
        for (int i = 0; i < n_goto; i++) begin
            if (gen_lines.size() != 0) begin
                pick = gen_lines[$urandom_range(0, gen_lines.size() - 1)];
            end else begin
                pick = LINE_W'($urandom);
            end
            case ($urandom_range(0, 9))
                0, 1:    push_req(ACT_GOTO, last_goto + 1'b1, 1'($urandom));
                2, 3:    push_req(ACT_GOTO, last_goto - 1'b1, 1'($urandom));
                4, 5:    push_req(ACT_GOTO, pick, 1'($urandom));
                6:       push_req(ACT_GOTO, ($urandom_range(0, 1) != 0) ? pick + 1'b1
                                                                     : pick - 1'b1,
                                  1'($urandom));
                7:       push_req(ACT_GOTO, LINE_W'($urandom), 1'($urandom));
                8:       push_req(ACT_GOTO, ($urandom_range(0, 1) != 0) ? LINE_MAX : '0,
                                  1'($urandom));
                default: push_noise();
            endcase
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin : drive
        int idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (n_issued < total_reqs / 3) begin
                idle_pct = 6;
            end else if (n_issued < 2 * total_reqs / 3) begin
                idle_pct = 85;
            end else begin
                idle_pct = 0;
            end
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                start <= 1'b1;
                i_req <= pending_reqs.pop_front();
                n_issued++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result checker and watchdog
    always @(posedge i_clk) begin : check
        t_rsp want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (lookup_results_due.size() == 0) begin
                    $error("result with no request outstanding: status %0d", o_rsp.status);
                    n_errs++;
                end else begin
                    want = lookup_results_due.pop_front();
                    if (o_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_rsp.status);
                        n_errs++;
                    end
                    if (o_rsp.selected_index !== want.selected_index) begin
                        $error("selected_index: expected %0d, actual %0d",
                               want.selected_index, o_rsp.selected_index);
                        n_errs++;
                    end
                    if (o_rsp.selected_line !== want.selected_line) begin
                        $error("selected_line: expected %0d, actual %0d",
                               want.selected_line, o_rsp.selected_line);
                        n_errs++;
                    end
                end
            end
            if (start && !busy) begin
                lookup_results_due.push_back(predict_lookup(i_req));
            end
            if (o_valid || (start && !busy)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= WDOG_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        int  n_dir;
        int  target;
        bit  filled;
        bit  do_fill;

        // Directed: deferral, empty table, neighbor steps, wraparound, fallback
        push_req(ACT_GOTO, 24'd100, 1'b0);
        push_req(ACT_FINISH, '0, 1'b0);
        push_req(ACT_FINISH, LINE_MAX, 1'b1);
        push_req(ACT_GOTO, 24'd5, 1'b1);
        push_req(ACT_CLEAR, LINE_MAX, 1'b1);
        push_req(ACT_APPEND, '0, 1'b0);
        push_req(ACT_APPEND, 24'd10, 1'b1);
        push_req(ACT_APPEND, 24'd20, 1'b0);
        push_req(ACT_APPEND, LINE_MAX, 1'b1);
        push_req(ACT_GOTO, '0, 1'b0);
        push_req(ACT_FINISH, '0, 1'b1);
        push_req(ACT_GOTO, 24'd15, 1'b0);
        push_req(ACT_GOTO, 24'd16, 1'b0);
        push_req(ACT_GOTO, 24'd15, 1'b0);
        push_req(ACT_GOTO, 24'd20, 1'b0);
        push_req(ACT_GOTO, 24'd19, 1'b0);
        push_req(ACT_GOTO, 24'd20, 1'b0);
        push_req(ACT_GOTO, LINE_MAX, 1'b1);
        push_req(ACT_GOTO, '0, 1'b0);
        push_req(ACT_GOTO, 24'd5, 1'b0);
        push_req(ACT_CLEAR, '0, 1'b0);
        push_req(ACT_APPEND, 24'd50, 1'b0);
        push_req(ACT_APPEND, 24'd30, 1'b0);
        push_req(ACT_FINISH, '0, 1'b1);
        push_req(ACT_GOTO, 24'd40, 1'b0);

        n_dir = pending_reqs.size();
        filled = 1'b0;
        target = n_dir + RAND_ITEMS;
        while (pending_reqs.size() < target) begin
            do_fill = !filled && (pending_reqs.size() > n_dir + 60);
            gen_session(do_fill);
            if (do_fill) begin
                filled = 1'b1;
            end
        end
        total_reqs = pending_reqs.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start || lookup_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errs == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sorted_line_predecessor_lookup.f
hw/rtl/slpl_pkg.sv
hw/rtl/slpl_mem.sv
hw/rtl/slpl_ctrl.sv
hw/rtl/sorted_line_predecessor_lookup.sv
hw/rtl/slpl_chk.sv
tb/sv/tb_sorted_line_predecessor_lookup.sv
